[hw/rtl/lsfa_pkg.sv]
// Shared types and constants for the LED strip frame animator.
package lsfa_pkg;

  localparam int N_LEDS_DEF    = 9;
  localparam int SCAN_LEDS_DEF = 9;

  localparam logic [2:0] MODE_DOT  = 3'd1;
  localparam logic [2:0] MODE_SCAN = 3'd5;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_RED      = 3'd1;
  localparam logic [2:0] REG_GREEN    = 3'd2;
  localparam logic [2:0] REG_BLUE     = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;

  localparam logic [7:0] LED_HEADER = 8'hFF;
  localparam logic [7:0] DOT_BLUE   = 8'hF1;
  localparam logic [7:0] DOT_GREEN  = 8'hEF;
  localparam logic [7:0] DOT_RED    = 8'hFF;
  localparam logic [7:0] SPOT_FADE  = 8'd246;
  localparam logic [7:0] FADE_STEP  = 8'd15;
  localparam logic [7:0] GLOW       = 8'd5;

  localparam int PRE_BYTES = 4;

  typedef struct packed {
    logic       start;
    logic [2:0] mode;
  } frame_req_t;

endpackage

[hw/rtl/lsfa_fade_mem.sv]
// Scanner fade level memory: registered read, valid bits for reset state.
module lsfa_fade_mem #(
  parameter int DEPTH = lsfa_pkg::SCAN_LEDS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);
  import lsfa_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : 8'd0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/lsfa_frame_gen.sv]
// Frame byte sequencer: preamble, LED records, trailer, with fade read-modify-write.
module lsfa_frame_gen #(
  parameter int N_LEDS    = lsfa_pkg::N_LEDS_DEF,
  parameter int SCAN_LEDS = lsfa_pkg::SCAN_LEDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsfa_pkg::frame_req_t req,
  input  logic [7:0]          base_red,
  input  logic [7:0]          base_green,
  input  logic [7:0]          base_blue,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_frame_byte,
  output logic                out_last_byte
);
  import lsfa_pkg::*;

  localparam int MAXL    = (N_LEDS > SCAN_LEDS) ? N_LEDS : SCAN_LEDS;
  localparam int LED_W   = $clog2(MAXL + 1);
  localparam int FA_W    = $clog2(SCAN_LEDS);
  localparam int TRAIL   = 5 + N_LEDS / 8;
  localparam int CNT_W   = $clog2(TRAIL);

  typedef enum logic [1:0] {S_IDLE, S_PRE, S_LED, S_POST} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LED_W-1:0]  led_r;
  logic [LED_W-1:0]  led_last_r;
  logic [1:0]        bsel_r;
  logic              scan_r;
  logic              hit_en_r;
  logic [LED_W-1:0]  hit_idx_r;
  logic [7:0]        pos_r;
  logic [7:0]        fade_new_r;
  logic              out_valid_r;
  logic [7:0]        byte_r;
  logic              last_r;

  logic              adv;
  logic              spot;
  logic              edge_led;
  logic              lit;
  logic [7:0]        fade_old;
  logic [7:0]        fade_new;
  logic [7:0]        scan_red;
  logic              fade_rd;
  logic              fade_wr;

  // start-of-frame position math
  logic [5:0]        phase;
  logic [7:0]        pos_inc;
  logic              start_hit_en;
  logic [LED_W-1:0]  start_hit_idx;
  logic [7:0]        start_pos_nxt;
  logic [5:0]        scan_cur;

  assign adv      = !out_valid_r || !out_stall;
  assign busy     = (state_r != S_IDLE) || out_valid_r;
  assign spot     = hit_en_r && (led_r == hit_idx_r);
  assign lit      = spot && !scan_r;
  assign edge_led = (led_r == '0) || (led_r == LED_W'(SCAN_LEDS - 1));
  assign fade_rd  = adv && (state_r == S_LED) && scan_r && (bsel_r == 2'd0);
  assign fade_wr  = adv && (state_r == S_LED) && scan_r && (bsel_r == 2'd1);
  assign scan_red = fade_new_r + GLOW;

  always_comb begin
    if (spot) begin
      fade_new = SPOT_FADE;
    end else if (fade_old >= FADE_STEP) begin
      fade_new = fade_old - FADE_STEP;
    end else begin
      fade_new = 8'd0;
    end
  end

  always_comb begin
    phase         = pos_r[7:2];
    pos_inc       = pos_r + 8'd1;
    scan_cur      = phase;
    start_hit_en  = 1'b0;
    start_hit_idx = '0;
    start_pos_nxt = 8'd0;
    if (req.mode == MODE_SCAN) begin
      start_hit_en  = 1'b1;
      start_pos_nxt = pos_inc;
      if (phase >= 6'(SCAN_LEDS)) begin
        if (phase >= 6'(2 * SCAN_LEDS)) begin
          scan_cur      = 6'd0;
          start_pos_nxt = 8'd0;
        end else begin
          scan_cur = 6'(2 * SCAN_LEDS - 1) - phase;
        end
      end
      start_hit_idx = scan_cur[LED_W-1:0];
    end else if (req.mode == MODE_DOT) begin
      start_hit_en  = pos_r < 8'(N_LEDS);
      start_hit_idx = pos_r[LED_W-1:0];
      start_pos_nxt = (pos_inc >= 8'(N_LEDS)) ? 8'd0 : pos_inc;
    end
  end

  lsfa_fade_mem #(
    .DEPTH (SCAN_LEDS),
    .AW    (FA_W)
  ) u_fade_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (fade_rd),
    .rd_addr (led_r[FA_W-1:0]),
    .wr_en   (fade_wr),
    .wr_addr (led_r[FA_W-1:0]),
    .wr_data (fade_new),
    .rd_data (fade_old)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= 8'd0;
      cnt_r       <= '0;
      led_r       <= '0;
      bsel_r      <= 2'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (adv) begin
            out_valid_r <= 1'b0;
          end
          if (req.start) begin
            scan_r     <= (req.mode == MODE_SCAN);
            led_last_r <= (req.mode == MODE_SCAN) ? LED_W'(SCAN_LEDS - 1)
                                                  : LED_W'(N_LEDS - 1);
            hit_en_r   <= start_hit_en;
            hit_idx_r  <= start_hit_idx;
            pos_r      <= start_pos_nxt;
            cnt_r      <= '0;
            led_r      <= '0;
            bsel_r     <= 2'd0;
            state_r    <= S_PRE;
          end
        end
        S_PRE: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            byte_r      <= 8'd0;
            last_r      <= 1'b0;
            if (cnt_r == CNT_W'(PRE_BYTES - 1)) begin
              cnt_r   <= '0;
              state_r <= S_LED;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_LED: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            last_r      <= 1'b0;
            bsel_r      <= bsel_r + 2'd1;
            unique case (bsel_r)
              2'd0: byte_r <= LED_HEADER;
              2'd1: begin
                fade_new_r <= fade_new;
                byte_r     <= scan_r ? 8'd0 : (lit ? DOT_BLUE : base_blue);
              end
              2'd2: begin
                if (scan_r) begin
                  byte_r <= (spot && edge_led) ? {2'b00, scan_red[7:2]} : 8'd0;
                end else begin
                  byte_r <= lit ? DOT_GREEN : base_green;
                end
              end
              default: begin
                byte_r <= scan_r ? scan_red : (lit ? DOT_RED : base_red);
                if (led_r == led_last_r) begin
                  state_r <= S_POST;
                end else begin
                  led_r <= led_r + 1'b1;
                end
              end
            endcase
          end
        end
        S_POST: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            byte_r      <= 8'd0;
            if (cnt_r == CNT_W'(TRAIL - 1)) begin
              last_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              last_r <= 1'b0;
              cnt_r  <= cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

endmodule

[hw/rtl/led_strip_frame_animator.sv]
// Top level: configuration registers, tick divider and frame byte sequencer.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, in_tick              | tick in
//  out     | out_valid, out_stall, out_frame_byte,    | bytes out
//          | out_last_byte                            |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| reg write
//
// A tick that emits no frame does not raise in_stall. A frame starts with a setup
// step, then emits one byte per cycle while out_stall is low: 4 + 4*L + 5 + N_LEDS/8
// bytes, L = SCAN_LEDS in scanner mode else N_LEDS (46 bytes at the defaults).
// in_stall stays high from the start of a frame until its last byte transfers.
// out_stall freezes the sequencer and the fade memory read-modify-write.
// Synchronous reset (rst_n low) clears mode, colours, fade levels; interval goes to 1.
module led_strip_frame_animator #(
  parameter int N_LEDS    = lsfa_pkg::N_LEDS_DEF,
  parameter int SCAN_LEDS = lsfa_pkg::SCAN_LEDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_tick,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import lsfa_pkg::*;

  logic [2:0] effect_mode_r;
  logic [7:0] base_red_r;
  logic [7:0] base_green_r;
  logic [7:0] base_blue_r;
  logic [7:0] interval_r;
  logic [7:0] divider_r;

  logic       busy;
  logic       in_xfer;
  frame_req_t req;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_xfer   = in_valid && !busy;

  assign req.start = in_xfer && in_tick && (divider_r == 8'd0);
  assign req.mode  = effect_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r <= 3'd0;
      base_red_r    <= 8'd0;
      base_green_r  <= 8'd0;
      base_blue_r   <= 8'd0;
      interval_r    <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:     effect_mode_r <= cfg_data[2:0];
        REG_RED:      base_red_r    <= cfg_data;
        REG_GREEN:    base_green_r  <= cfg_data;
        REG_BLUE:     base_blue_r   <= cfg_data;
        REG_INTERVAL: interval_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r <= 8'd1;
    end else if (in_xfer && in_tick) begin
      divider_r <= (divider_r == 8'd0) ? interval_r : divider_r - 8'd1;
    end
  end

  lsfa_frame_gen #(
    .N_LEDS    (N_LEDS),
    .SCAN_LEDS (SCAN_LEDS)
  ) u_frame_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .base_red       (base_red_r),
    .base_green     (base_green_r),
    .base_blue      (base_blue_r),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

[sim/led_strip_frame_animator_tb.sv]
// Self-checking testbench for the LED strip frame animator: directed table, then random phases.
module led_strip_frame_animator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsfa_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int N_LEDS        = N_LEDS_DEF;
  localparam int SCAN_LEDS     = SCAN_LEDS_DEF;
  localparam int POS_SHIFT     = 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 130;
  localparam int QUIET_ITEMS   = 30;

  localparam logic [2:0] MODE_STATIC = 3'd0;
  localparam logic [2:0] MODE_SPARE  = 3'd7;  // unused code, runs as static
  localparam logic [2:0] REG_NONE    = 3'd7;  // unmapped register index

  typedef enum { ROW_CFG, ROW_TICK, ROW_NO_FRAME, ROW_SOLID } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [2:0] idx;
    logic [7:0] val;
    logic       tick;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } strip_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_tick;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_frame_byte;
  logic       out_last_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  led_strip_frame_animator #(
    .N_LEDS   (N_LEDS),
    .SCAN_LEDS(SCAN_LEDS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tick       (in_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the block's registers and animation state
  logic [2:0] mode_r;
  logic [7:0] base_r, base_g, base_b, interval_r;
  logic [7:0] div_cnt;
  logic [7:0] anim_pos;
  logic [7:0] fade [SCAN_LEDS];

  strip_byte_t frame_buf [$];
  strip_byte_t pending_bytes [$];

  bit quiet;
  int tx_calm;
  int mismatch_count, bytes_seen, ticks_sent, cfg_writes, cycle_count;
  int static_frames, dot_frames, scan_frames, sweep_wraps;

  stim_row_t dir_rows [0:31] = '{
    '{ROW_NO_FRAME, REG_MODE,     8'h00,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_NO_FRAME, REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_SOLID,    REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_RED,      8'hFF,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_GREEN,    8'h00,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_BLUE,     8'hA5,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_INTERVAL, 8'h00,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_NONE,     8'h5A,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_NO_FRAME, REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_SOLID,    REG_MODE,     8'h00,     1'b1, 8'hA5, 8'h00, 8'hFF},
    '{ROW_NO_FRAME, REG_MODE,     8'h00,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_SOLID,    REG_MODE,     8'h00,     1'b1, 8'hA5, 8'h00, 8'hFF},
    '{ROW_CFG,      REG_MODE,     {5'd0, MODE_SPARE}, 1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_SOLID,    REG_MODE,     8'h00,     1'b1, 8'hA5, 8'h00, 8'hFF},
    '{ROW_CFG,      REG_MODE,     {5'd0, MODE_DOT},   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_MODE,     {5'd0, MODE_SCAN},  1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_MODE,     {5'd0, MODE_DOT},   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_TICK,     REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_CFG,      REG_MODE,     {5'd0, MODE_STATIC}, 1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_SOLID,    REG_MODE,     8'h00,     1'b1, 8'hA5, 8'h00, 8'hFF},
    '{ROW_CFG,      REG_INTERVAL, 8'h06,     1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_SOLID,    REG_MODE,     8'h00,     1'b1, 8'hA5, 8'h00, 8'hFF},
    '{ROW_NO_FRAME, REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00},
    '{ROW_NO_FRAME, REG_MODE,     8'h00,     1'b1, 8'h00, 8'h00, 8'h00}
  };

  function automatic void put_byte(logic [7:0] b);
    frame_buf.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void put_led(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    put_byte(LED_HEADER);
    put_byte(b);
    put_byte(g);
    put_byte(r);
  endfunction

  function automatic void frame_open();
    frame_buf.delete();
    repeat (PRE_BYTES) put_byte(8'h00);
  endfunction

  // end zeros: four, then N_LEDS/8 plus one more
  function automatic void frame_close();
    repeat (4 + N_LEDS / 8 + 1) put_byte(8'h00);
    frame_buf[$].last = 1'b1;
  endfunction

  // lit at N_LEDS or above means no white LED (static mode or stale position)
  function automatic void paint_dot(logic [7:0] lit);
    logic [7:0] nxt;
    for (int i = 0; i < N_LEDS; i++) begin
      if (i == lit) put_led(DOT_BLUE, DOT_GREEN, DOT_RED);
      else put_led(base_b, base_g, base_r);
    end
    nxt = lit + 8'd1;
    anim_pos = (nxt >= N_LEDS) ? 8'd0 : nxt;
  endfunction

  function automatic void paint_scan();
    int         phase_pos;
    int         spot;
    logic [7:0] red;
    logic [7:0] grn;
    phase_pos = anim_pos;
    spot = phase_pos >> POS_SHIFT;
    if (spot >= SCAN_LEDS) begin
      if (spot >= 2 * SCAN_LEDS) begin
        // sweep done: spot back at LED 0, position restarts
        spot = 0;
        phase_pos = 255;
        sweep_wraps++;
      end else begin
        spot = 2 * SCAN_LEDS - 1 - spot;
      end
    end
    anim_pos = 8'(phase_pos + 1);
    for (int i = 0; i < SCAN_LEDS; i++) begin
      if (i == spot) fade[i] = SPOT_FADE;
      else if (fade[i] >= FADE_STEP) fade[i] = fade[i] - FADE_STEP;
      else fade[i] = 8'd0;
      red = fade[i] + GLOW;
      grn = (i == spot && (i == 0 || i == SCAN_LEDS - 1)) ? (red >> 2) : 8'd0;
      put_led(8'd0, grn, red);
    end
  endfunction

  // Leaves the bytes of the resulting frame in frame_buf (empty when none)
  function automatic void predict_tick(logic t);
    frame_buf.delete();
    if (!t) return;
    if (div_cnt != 0) begin
      div_cnt--;
      return;
    end
    div_cnt = interval_r;
    frame_open();
    if (mode_r == MODE_DOT) begin
      paint_dot(anim_pos);
      dot_frames++;
    end else if (mode_r == MODE_SCAN) begin
      paint_scan();
      scan_frames++;
    end else begin
      paint_dot(8'(N_LEDS));
      static_frames++;
    end
    frame_close();
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Drops in_valid, waits for every expected byte, then lets the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:     mode_r = val[2:0];
      REG_RED:      base_r = val;
      REG_GREEN:    base_g = val;
      REG_BLUE:     base_b = val;
      REG_INTERVAL: interval_r = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // in_valid stays high after the transfer; the next call or wait_drained handles it
  task automatic send_tick(logic t, row_kind_t how, logic [7:0] b, logic [7:0] g,
                           logic [7:0] r);
    int gap;
    @(negedge clk);
    if (tx_calm > 0) begin
      tx_calm--;
    end else if (!quiet && $urandom_range(0, 29) == 0) begin
      tx_calm = $urandom_range(20, 60);
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= t;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    predict_tick(t);
    if (how == ROW_SOLID) begin
      frame_open();
      repeat (N_LEDS) put_led(b, g, r);
      frame_close();
    end
    if (how != ROW_NO_FRAME) begin
      foreach (frame_buf[k]) pending_bytes.push_back(frame_buf[k]);
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] want_b, logic want_l);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $time, what, want_b, want_l, out_frame_byte, out_last_byte);
  endtask

  always @(posedge clk) begin : check_bytes
    strip_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", 8'hxx, 1'bx);
      end else begin
        want = pending_bytes.pop_front();
        if (out_frame_byte !== want.data || out_last_byte !== want.last)
          report_mismatch("frame byte mismatch", want.data, want.last);
      end
    end
  end

  // Receiver stalls: random-length bursts, with calm stretches
  int stall_left, calm_left;
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 150) == 0) begin
      calm_left = $urandom_range(40, 300);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected",
               cycle_count, pending_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_items;
    int sel;
    int span;
    int target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_tick   = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = 8'h00;
    mode_r     = MODE_STATIC;
    base_r     = 8'h00;
    base_g     = 8'h00;
    base_b     = 8'h00;
    interval_r = 8'd1;
    div_cnt    = 8'd1;
    anim_pos   = 8'd0;
    foreach (fade[i]) fade[i] = 8'd0;
    rand_items = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG)
        write_reg(dir_rows[n].idx, dir_rows[n].val);
      else
        send_tick(dir_rows[n].tick, dir_rows[n].kind, dir_rows[n].b, dir_rows[n].g,
                  dir_rows[n].r);
    end

    // count down the divider left by the longer interval
    while (div_cnt != 0) send_tick(1'b1, ROW_TICK, 8'h00, 8'h00, 8'h00);
    send_tick(1'b1, ROW_TICK, 8'h00, 8'h00, 8'h00);

    // full scanner sweep including the restart, then dot from a stale position
    write_reg(REG_INTERVAL, 8'd0);
    write_reg(REG_MODE, MODE_SCAN);
    target = scan_frames + 75;
    while (scan_frames < target || anim_pos < 20 || anim_pos > 60)
      send_tick(1'b1, ROW_TICK, 8'h00, 8'h00, 8'h00);
    write_reg(REG_MODE, MODE_DOT);
    repeat (12) send_tick(1'b1, ROW_TICK, 8'h00, 8'h00, 8'h00);

    while (rand_items < RANDOM_ITEMS) begin
      quiet = (rand_items >= RANDOM_ITEMS - QUIET_ITEMS);
      // no register writes in the final stretch so the input never idles there
      if (!quiet) begin
        sel = $urandom_range(0, 9);
        write_reg(REG_MODE, sel < 4 ? MODE_DOT : sel < 7 ? MODE_SCAN : 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1)) write_reg(REG_RED, pick_level());
        if ($urandom_range(0, 1)) write_reg(REG_GREEN, pick_level());
        if ($urandom_range(0, 1)) write_reg(REG_BLUE, pick_level());
        if ($urandom_range(0, 1))
          write_reg(REG_INTERVAL, $urandom_range(0, 7) == 0 ? 8'($urandom_range(4, 10))
                                                             : 8'($urandom_range(0, 3)));
      end
      span = $urandom_range(4, 24);
      repeat (span) begin
        if (!quiet && $urandom_range(0, 24) == 0) wait_drained();
        send_tick($urandom_range(0, 9) != 0, ROW_TICK, 8'h00, 8'h00, 8'h00);
        rand_items++;
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("Ran %0d ticks and %0d register writes; %0d frame bytes checked.",
             ticks_sent, cfg_writes, bytes_seen);
    $display("Frames: %0d static, %0d dot, %0d scanner (%0d sweep restarts); %0d mismatches.",
             static_frames, dot_frames, scan_frames, sweep_wraps, mismatch_count);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lsfa_pkg.sv
hw/rtl/lsfa_fade_mem.sv
hw/rtl/lsfa_frame_gen.sv
hw/rtl/led_strip_frame_animator.sv
sim/led_strip_frame_animator_tb.sv
